>>> sv/tilt_angle_alarm_debounced_defines.svh
// Assertion helpers for the tilt alarm block.
`ifndef TILT_ANGLE_ALARM_DEBOUNCED_DEFINES_SVH
`define TILT_ANGLE_ALARM_DEBOUNCED_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TAAD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt alarm check failed");

// Next-cycle implication, checked outside reset.
`define TAAD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt alarm check failed");

`endif

>>> sv/taad_pkg.sv
package taad_pkg;

  // Debounce length: the alarm changes after more than this many samples in a row.
  localparam int DEBOUNCE_COUNT = 4;
  localparam int RUN_W = 3;

  // Ratio format: unsigned fixed point with this many fraction bits.
  localparam int RATIO_FRAC_BITS = 8;
  localparam int RATIO_W = RATIO_FRAC_BITS + 1;
  localparam int ROM_DEPTH = 1 << RATIO_FRAC_BITS;
  localparam int ROM_IDX_W = RATIO_FRAC_BITS;

  // Raw count and scaling.
  localparam int COUNT_W = 10;
  localparam int RANGE_W = 2;
  localparam int G_SHIFT = 8;
  localparam int ROUND_HALF = 1 << (G_SHIFT - 1);
  localparam int SCALED_W = COUNT_W + RATIO_FRAC_BITS + (1 << RANGE_W) + 1;
  localparam int QRAW_W = SCALED_W - G_SHIFT;

  // Angle codes, 0.0001 rad units.
  localparam int ANGLE_W = 15;
  localparam int DIFF_W = ANGLE_W + 1;
  localparam int WRAP_W = ANGLE_W + 2;
  localparam logic [ANGLE_W-1:0] PI_E4 = 15'd31416;
  localparam logic [WRAP_W-1:0] TWO_PI_E4 = 17'd62832;

  // Fine angle units, 1e-7 rad.
  localparam longint PI_E7 = 64'sd31415927;
  localparam longint HALF_PI_E7 = 64'sd15707963;
  localparam longint E7_PER_E4 = 64'sd1000;
  localparam longint E7_ROUND = 64'sd500;
  localparam int CORDIC_STEPS = 24;
  localparam longint ATAN_E7 [CORDIC_STEPS] = '{
    64'sd7853982, 64'sd4636476, 64'sd2449787, 64'sd1243550, 64'sd624188, 64'sd312398,
    64'sd156237, 64'sd78123, 64'sd39062, 64'sd19531, 64'sd9766, 64'sd4883,
    64'sd2441, 64'sd1221, 64'sd610, 64'sd305, 64'sd153, 64'sd76,
    64'sd38, 64'sd19, 64'sd10, 64'sd5, 64'sd2, 64'sd1
  };

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANGLE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANGLE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANGLE_Z = 3'd4;

  // Register reset values.
  localparam logic [RANGE_W-1:0] RANGE_SELECT_RST = 2'd1;
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT_RST = 15'd5236;
  localparam logic [ANGLE_W-1:0] BASE_ANGLE_X_RST = 15'd15707;
  localparam logic [ANGLE_W-1:0] BASE_ANGLE_Y_RST = 15'd15707;
  localparam logic [ANGLE_W-1:0] BASE_ANGLE_Z_RST = 15'd0;

  typedef logic [ANGLE_W-1:0] acos_rom_t [ROM_DEPTH];

  // Angle code for ratio q, by square root and a 24-step vectoring CORDIC.
  // Evaluated at elaboration only, to fill the arccos tables.
  function automatic logic [ANGLE_W-1:0] acos_code(longint q, bit neg);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint a;
    longint unsigned xs;
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    if (q >= (64'sd1 << RATIO_FRAC_BITS)) begin
      a = 0;
    end else begin
      xs = longint'(q) << (30 - RATIO_FRAC_BITS);
      n = (64'd1 << 60) - xs * xs;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) begin
        b = b >> 2;
      end
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      x = longint'(xs);
      y = longint'(r);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_E7[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_E7[i];
        end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_E7) z = HALF_PI_E7;
      a = z;
    end
    if (neg) a = PI_E7 - a;
    return ANGLE_W'((a + E7_ROUND) / E7_PER_E4);
  endfunction

  // Full arccos table for one sign of the count.
  function automatic acos_rom_t acos_rom(bit neg);
    acos_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = acos_code(longint'(i), neg);
    end
    return rom;
  endfunction

  localparam acos_rom_t ACOS_POS = acos_rom(1'b0);
  localparam acos_rom_t ACOS_NEG = acos_rom(1'b1);
  localparam logic [ANGLE_W-1:0] CODE_FULL_POS = acos_code(longint'(ROM_DEPTH), 1'b0);
  localparam logic [ANGLE_W-1:0] CODE_FULL_NEG = acos_code(longint'(ROM_DEPTH), 1'b1);

endpackage

>>> sv/tilt_angle_alarm_debounced.sv
// A transferred sample is held in the input register and its result is then
// registered in the result register. Throughput: one sample per cycle; the path is
// input register, unpack and scale, arccos table, angle compare, debounce update,
// result register. Back-pressure on the result side stalls the input register
// and then the input. Reset (rst, synchronous) clears both valid flags and the
// debounce state and loads the configuration registers with their default values.
`include "tilt_angle_alarm_debounced_defines.svh"

module tilt_angle_alarm_debounced
  import taad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  logic [7:0]            x_low_byte,
  input  logic [7:0]            x_high_byte,
  input  logic [7:0]            y_low_byte,
  input  logic [7:0]            y_high_byte,
  input  logic [7:0]            z_low_byte,
  input  logic [7:0]            z_high_byte,
  input  logic                  read_error,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  tilt_alarm,
  output logic                  tilted_now,
  output logic                  sample_used,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [RANGE_W-1:0] range_select;
  logic [ANGLE_W-1:0] angle_limit;
  logic [ANGLE_W-1:0] base_angle_x;
  logic [ANGLE_W-1:0] base_angle_y;
  logic [ANGLE_W-1:0] base_angle_z;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_x_lo;
  logic [7:0] s1_x_hi;
  logic [7:0] s1_y_lo;
  logic [7:0] s1_y_hi;
  logic [7:0] s1_z_lo;
  logic [7:0] s1_z_hi;
  logic       s1_err;

  // Debounce state.
  logic [RUN_W-1:0] tilt_run;
  logic [RUN_W-1:0] level_run;
  logic             alarm_level;
  logic [RUN_W-1:0] tilt_run_next;
  logic [RUN_W-1:0] level_run_next;
  logic             alarm_level_next;

  logic advance;
  logic tilted;
  logic [DIFF_W-1:0] diff_x;
  logic [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0] diff_z;

  // Unpack one axis, scale to a ratio of 1 g and look up its angle code.
  function automatic logic [ANGLE_W-1:0] axis_code(logic [7:0] lo, logic [7:0] hi,
                                                   logic [RANGE_W-1:0] rs);
    logic [COUNT_W-1:0]  raw;
    logic                neg;
    logic [COUNT_W-1:0]  mag;
    logic [SCALED_W-1:0] scaled;
    logic [QRAW_W-1:0]   q_raw;
    logic                full;
    logic [ROM_IDX_W-1:0] idx;
    raw = {hi, lo[7:6]};
    neg = raw[COUNT_W-1];
    mag = neg ? (~raw + COUNT_W'(1)) : raw;
    scaled = (SCALED_W'(mag) << (RATIO_FRAC_BITS + int'(rs))) + SCALED_W'(ROUND_HALF);
    q_raw = scaled[SCALED_W-1:G_SHIFT];
    full = (q_raw >= QRAW_W'(ROM_DEPTH));
    idx = q_raw[ROM_IDX_W-1:0];
    if (full) begin
      return neg ? CODE_FULL_NEG : CODE_FULL_POS;
    end
    return neg ? ACOS_NEG[idx] : ACOS_POS[idx];
  endfunction

  // Distance to the baseline, wrapped the short way around the circle.
  function automatic logic [DIFF_W-1:0] angle_diff(logic [ANGLE_W-1:0] code,
                                                   logic [ANGLE_W-1:0] base);
    logic [ANGLE_W-1:0] d;
    logic [WRAP_W-1:0]  w;
    d = (code > base) ? (code - base) : (base - code);
    w = TWO_PI_E4 - WRAP_W'(d);
    if (d >= PI_E4) begin
      return w[DIFF_W-1:0];
    end
    return DIFF_W'(d);
  endfunction

  // The registers accept every write.
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_select <= RANGE_SELECT_RST;
      angle_limit <= ANGLE_LIMIT_RST;
      base_angle_x <= BASE_ANGLE_X_RST;
      base_angle_y <= BASE_ANGLE_Y_RST;
      base_angle_z <= BASE_ANGLE_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_SELECT: range_select <= cfg_data[RANGE_W-1:0];
        REG_ANGLE_LIMIT:  angle_limit <= cfg_data[ANGLE_W-1:0];
        REG_BASE_ANGLE_X: base_angle_x <= cfg_data[ANGLE_W-1:0];
        REG_BASE_ANGLE_Y: base_angle_y <= cfg_data[ANGLE_W-1:0];
        REG_BASE_ANGLE_Z: base_angle_z <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // The result register can take a new result when it is empty or being drained.
  assign advance = !result_valid || result_ready;
  assign sample_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
    if (sample_valid && sample_ready) begin
      s1_x_lo <= x_low_byte;
      s1_x_hi <= x_high_byte;
      s1_y_lo <= y_low_byte;
      s1_y_hi <= y_high_byte;
      s1_z_lo <= z_low_byte;
      s1_z_hi <= z_high_byte;
      s1_err <= read_error;
    end
  end

  // Per-axis angle distances and the tilt decision.
  always_comb begin
    diff_x = angle_diff(axis_code(s1_x_lo, s1_x_hi, range_select), base_angle_x);
    diff_y = angle_diff(axis_code(s1_y_lo, s1_y_hi, range_select), base_angle_y);
    diff_z = angle_diff(axis_code(s1_z_lo, s1_z_hi, range_select), base_angle_z);
    tilted = (diff_x >= DIFF_W'(angle_limit)) || (diff_y >= DIFF_W'(angle_limit))
          || (diff_z >= DIFF_W'(angle_limit));
  end

  // Debounce counters: one run counts, the other is cleared; read errors hold both.
  always_comb begin
    tilt_run_next = tilt_run;
    level_run_next = level_run;
    alarm_level_next = alarm_level;
    if (!s1_err) begin
      if (tilted) begin
        level_run_next = '0;
        if (tilt_run < RUN_W'(DEBOUNCE_COUNT)) begin
          tilt_run_next = tilt_run + RUN_W'(1);
        end else begin
          alarm_level_next = 1'b1;
        end
      end else begin
        tilt_run_next = '0;
        if (level_run < RUN_W'(DEBOUNCE_COUNT)) begin
          level_run_next = level_run + RUN_W'(1);
        end else begin
          alarm_level_next = 1'b0;
        end
      end
    end
  end

  // State update and result register, one sample per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_run <= '0;
      level_run <= '0;
      alarm_level <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
      if (s1_valid) begin
        tilt_run <= tilt_run_next;
        level_run <= level_run_next;
        alarm_level <= alarm_level_next;
      end
    end
    if (advance && s1_valid) begin
      tilt_alarm <= alarm_level_next;
      tilted_now <= tilted && !s1_err;
      sample_used <= !s1_err;
    end
  end

  // Only one of the two runs can be in progress.
  `TAAD_ASSERT_NOW(a_one_run, 1'b1, (tilt_run == '0) || (level_run == '0))
  // The alarm sets only after a full run of tilted samples.
  `TAAD_ASSERT_NOW(a_alarm_set, $rose(alarm_level),
                   $past(tilt_run) == RUN_W'(DEBOUNCE_COUNT))
  // An ignored sample never reports a tilt.
  `TAAD_ASSERT_NOW(a_unused_level, result_valid && !sample_used, !tilted_now)
  // A sample held in the input register is not lost while the output stalls.
  `TAAD_ASSERT_NEXT(a_hold_s1, s1_valid && !advance, s1_valid)

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import taad_pkg::*;

  // Predictor constants for the debounce and the ratio format.
  localparam int RUN_LIMIT = 4;
  localparam int FRAC_BITS = 8;
  localparam longint unsigned RATIO_ONE = 64'd1 << FRAC_BITS;
  localparam longint ANGLE_PI_FINE = 64'sd31415927;
  localparam longint ANGLE_HALF_PI_FINE = 64'sd15707963;
  localparam int unsigned ANGLE_PI_CODE = 31416;
  localparam int unsigned ANGLE_TWO_PI_CODE = 62832;
  localparam int MAX_PRINTED = 40;
  localparam int LONG_STALL_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 200;

  // Register indexes past the end of the register list.
  localparam int SPARE_REG_FIRST = int'(REG_BASE_ANGLE_Z) + 1;
  localparam int SPARE_REG_LAST = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;
    logic       read_error;
  } accel_sample_t;

  typedef struct packed {
    logic tilt_alarm;
    logic tilted_now;
    logic sample_used;
  } alarm_result_t;

  // Tracks the block's registers and debounce state and holds the alarm results
  // that accepted samples should produce, oldest first.
  class tilt_scoreboard;
    logic [1:0]    range_sel;
    logic [14:0]   limit_code;
    logic [14:0]   base_x;
    logic [14:0]   base_y;
    logic [14:0]   base_z;
    logic [2:0]    tilt_run;
    logic [2:0]    level_run;
    logic          alarm_on;
    alarm_result_t pending_alarms[$];
    int            mismatches;
    int            results_seen;

    function new();
      range_sel = 2'd1;
      limit_code = 15'd5236;
      base_x = 15'd15707;
      base_y = 15'd15707;
      base_z = 15'd0;
      tilt_run = '0;
      level_run = '0;
      alarm_on = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
      end
      mismatches++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RANGE_SELECT: range_sel = data[1:0];
        REG_ANGLE_LIMIT:  limit_code = data[14:0];
        REG_BASE_ANGLE_X: base_x = data[14:0];
        REG_BASE_ANGLE_Y: base_y = data[14:0];
        REG_BASE_ANGLE_Z: base_z = data[14:0];
        default: ;
      endcase
    endfunction

    // Angle of one axis in 0.0001 rad: scale the count to a ratio of 1 g, then
    // take the arccos by square root and a vectoring CORDIC.
    function int unsigned axis_angle(logic [7:0] lo, logic [7:0] hi);
      logic [9:0]        raw;
      logic              neg;
      longint unsigned   mag;
      longint unsigned   q;
      longint unsigned   xs;
      longint unsigned   n;
      longint unsigned   r;
      longint unsigned   b;
      longint            x;
      longint            y;
      longint            z;
      longint            dx;
      longint            dy;
      longint            a;
      raw = {hi, lo[7:6]};
      neg = raw[9];
      mag = neg ? 64'd1024 - 64'(raw) : 64'(raw);
      q = ((mag << (FRAC_BITS + int'(range_sel))) + 64'd128) >> 8;
      if (q > RATIO_ONE) q = RATIO_ONE;
      if (q == RATIO_ONE) begin
        a = 0;
      end else begin
        xs = q << (30 - FRAC_BITS);
        n = (64'd1 << 60) - xs * xs;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
          if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
        x = longint'(xs);
        y = longint'(r);
        z = 0;
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(i);
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(i);
          end
        end
        if (z < 0) z = 0;
        if (z > ANGLE_HALF_PI_FINE) z = ANGLE_HALF_PI_FINE;
        a = z;
      end
      if (neg) a = ANGLE_PI_FINE - a;
      return int'((a + 500) / 1000);
    endfunction

    // atan(2^-i) in 1e-7 rad, rounded to nearest.
    function longint atan_step(int i);
      case (i)
        0: return 7853982;   1: return 4636476;   2: return 2449787;  3: return 1243550;
        4: return 624188;    5: return 312398;    6: return 156237;   7: return 78123;
        8: return 39062;     9: return 19531;     10: return 9766;    11: return 4883;
        12: return 2441;     13: return 1221;     14: return 610;     15: return 305;
        16: return 153;      17: return 76;       18: return 38;      19: return 19;
        20: return 10;       21: return 5;        22: return 2;       default: return 1;
      endcase
    endfunction

    // Distance between two angle codes, folded back when it passes pi.
    function int unsigned angle_gap(int unsigned code, int unsigned base);
      int unsigned d;
      d = (code > base) ? code - base : base - code;
      if (d >= ANGLE_PI_CODE) begin
        d = (d > ANGLE_TWO_PI_CODE) ? d - ANGLE_TWO_PI_CODE : ANGLE_TWO_PI_CODE - d;
      end
      return d;
    endfunction

    // Advance the debounce state for one transferred sample.
    function void note_sample(accel_sample_t s);
      alarm_result_t res;
      logic tilted;
      if (s.read_error) begin
        res = '{tilt_alarm: alarm_on, tilted_now: 1'b0, sample_used: 1'b0};
      end else begin
        tilted =
          angle_gap(axis_angle(s.x_low_byte, s.x_high_byte), base_x) >= limit_code ||
          angle_gap(axis_angle(s.y_low_byte, s.y_high_byte), base_y) >= limit_code ||
          angle_gap(axis_angle(s.z_low_byte, s.z_high_byte), base_z) >= limit_code;
        if (tilted) begin
          level_run = '0;
          if (tilt_run < RUN_LIMIT) tilt_run = tilt_run + 3'd1;
          else alarm_on = 1'b1;
        end else begin
          tilt_run = '0;
          if (level_run < RUN_LIMIT) level_run = level_run + 3'd1;
          else alarm_on = 1'b0;
        end
        res = '{tilt_alarm: alarm_on, tilted_now: tilted, sample_used: 1'b1};
      end
      pending_alarms.push_back(res);
    endfunction

    // Compare one transferred result with the oldest pending one.
    task check_result(alarm_result_t got);
      alarm_result_t want;
      results_seen++;
      if (pending_alarms.size() == 0) begin
        report_mismatch("result transferred with none pending");
      end else begin
        want = pending_alarms.pop_front();
        if (got.tilt_alarm !== want.tilt_alarm)
          report_mismatch($sformatf("tilt_alarm got %b, wanted %b",
                                    got.tilt_alarm, want.tilt_alarm));
        if (got.tilted_now !== want.tilted_now)
          report_mismatch($sformatf("tilted_now got %b, wanted %b",
                                    got.tilted_now, want.tilted_now));
        if (got.sample_used !== want.sample_used)
          report_mismatch($sformatf("sample_used got %b, wanted %b",
                                    got.sample_used, want.sample_used));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_ready;
  logic [7:0]            x_low_byte;
  logic [7:0]            x_high_byte;
  logic [7:0]            y_low_byte;
  logic [7:0]            y_high_byte;
  logic [7:0]            z_low_byte;
  logic [7:0]            z_high_byte;
  logic                  read_error;
  logic                  result_valid;
  logic                  result_ready;
  logic                  tilt_alarm;
  logic                  tilted_now;
  logic                  sample_used;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tilt_scoreboard sb = new();

  // Idle rates in percent, and long result stalls asked of the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_stall_requests = 0;

  tilt_angle_alarm_debounced dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .x_low_byte   (x_low_byte),
    .x_high_byte  (x_high_byte),
    .y_low_byte   (y_low_byte),
    .y_high_byte  (y_high_byte),
    .z_low_byte   (z_low_byte),
    .z_high_byte  (z_high_byte),
    .read_error   (read_error),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tilt_alarm   (tilt_alarm),
    .tilted_now   (tilted_now),
    .sample_used  (sample_used),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Watch every channel at the rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (sample_valid && sample_ready) begin
        sb.note_sample({x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                        z_low_byte, z_high_byte, read_error});
      end
      if (result_valid && result_ready) sb.check_result({tilt_alarm, tilted_now, sample_used});
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_sink
    int stalls_served;
    int hold;
    stalls_served = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_served < long_stall_requests) begin
        stalls_served++;
        hold = LONG_STALL_CYCLES;
        while (hold > 0) begin
          result_ready <= 1'b0;
          @(negedge clk);
          hold--;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up if the run hangs.
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  // Raw register bytes for one axis count, with random bits below the count.
  function automatic logic [15:0] axis_bytes(int count);
    logic [9:0] v;
    if (count > 511) count = 511;
    if (count < -512) count = -512;
    v = count[9:0];
    return {v[9:2], v[1:0], 6'($urandom)};
  endfunction

  function automatic accel_sample_t pose_sample(int cx, int cy, int cz, logic err);
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] bz;
    bx = axis_bytes(cx);
    by = axis_bytes(cy);
    bz = axis_bytes(cz);
    return {bx[7:0], bx[15:8], by[7:0], by[15:8], bz[7:0], bz[15:8], err};
  endfunction

  function automatic int nudge(int c);
    return c + int'($urandom_range(6)) - 3;
  endfunction

  // Offer one sample and hold it until it transfers. Valid only drops while idling.
  task automatic send_sample(accel_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    x_low_byte <= s.x_low_byte;
    x_high_byte <= s.x_high_byte;
    y_low_byte <= s.y_low_byte;
    y_high_byte <= s.y_high_byte;
    z_low_byte <= s.z_low_byte;
    z_high_byte <= s.z_high_byte;
    read_error <= s.read_error;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // Stop offering samples until every pending result has transferred.
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_alarms.size() != 0);
  endtask

  task automatic write_cfg(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] range_data, int limit,
                                int bx, int by, int bz);
    wait_for_results();
    write_cfg(REG_RANGE_SELECT, range_data);
    write_cfg(REG_ANGLE_LIMIT, limit[14:0]);
    write_cfg(REG_BASE_ANGLE_X, bx[14:0]);
    write_cfg(REG_BASE_ANGLE_Y, by[14:0]);
    write_cfg(REG_BASE_ANGLE_Z, bz[14:0]);
    cfg_valid <= 1'b0;
  endtask

  // Mostly runs of one held pose with jitter, so the debounce counters fill up;
  // the rest is unrelated noise.
  task automatic random_phase(bit pause_mid, bit stall_mid);
    int sent;
    int g;
    int cx;
    int cy;
    int cz;
    int axis;
    int run_len;
    bit pause_done;
    bit stall_done;
    accel_sample_t s;
    sent = 0;
    pause_done = 1'b0;
    stall_done = 1'b0;
    while (sent < ITEMS_PER_PHASE) begin
      if (pause_mid && !pause_done && sent >= ITEMS_PER_PHASE / 2) begin
        pause_done = 1'b1;
        wait_for_results();
      end
      if (stall_mid && !stall_done && sent >= ITEMS_PER_PHASE / 3) begin
        stall_done = 1'b1;
        long_stall_requests++;
      end
      g = 256 >> sb.range_sel;
      if ($urandom_range(99) < 20) begin
        s = 49'({$urandom, $urandom});
        send_sample(s);
        sent++;
      end else begin
        cx = 0;
        cy = 0;
        cz = 0;
        if ($urandom_range(1) == 0) begin
          // Gravity along one axis, either sign.
          axis = $urandom_range(5);
          case (axis % 3)
            0: cx = (axis < 3) ? g : -g;
            1: cy = (axis < 3) ? g : -g;
            default: cz = (axis < 3) ? g : -g;
          endcase
        end else begin
          cx = int'($urandom_range(2 * g + 16)) - (g + 8);
          cy = int'($urandom_range(2 * g + 16)) - (g + 8);
          cz = int'($urandom_range(2 * g + 16)) - (g + 8);
        end
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          s = pose_sample(nudge(cx), nudge(cy), nudge(cz), $urandom_range(11) == 0);
          send_sample(s);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    x_low_byte = '0;
    x_high_byte = '0;
    y_low_byte = '0;
    y_high_byte = '0;
    z_low_byte = '0;
    z_high_byte = '0;
    read_error = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed samples at the reset configuration, where 1 g is 128 counts.
    // Gravity on X is tilted; a read error inside the run must not break it.
    repeat (3) send_sample(pose_sample(128, 0, 0, 1'b0));
    send_sample(pose_sample(128, 0, 0, 1'b1));
    repeat (3) send_sample(pose_sample(128, 0, 0, 1'b0));
    // A read error while the alarm is set reports the held level.
    send_sample(pose_sample(-3, 77, 5, 1'b1));
    // Gravity on Z is level and clears the alarm after the debounce.
    repeat (6) send_sample(pose_sample(0, 0, 128, 1'b0));
    // Extreme raw bytes: zero, all ones, largest and smallest counts, low junk.
    send_sample({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    send_sample({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_sample({8'hC0, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'h7F, 1'b0});
    send_sample({8'h00, 8'h80, 8'hC0, 8'h7F, 8'h3F, 8'h80, 1'b0});
    send_sample({8'h3F, 8'h00, 8'h3F, 8'h00, 8'hC0, 8'h20, 1'b0});
    send_sample({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});

    // Defaults rewritten with junk above the range bits, plus the spare indexes.
    wait_for_results();
    for (int i = SPARE_REG_FIRST; i <= SPARE_REG_LAST; i++) write_cfg(i, 15'($urandom));
    apply_settings(15'({$urandom_range(8191), 2'd1}), 5236, 15707, 15707, 0);
    random_phase(1'b0, 1'b1);

    // Widest range, zero limit: every used sample is tilted.
    send_idle_pct = 70;
    apply_settings(15'd0, 0, 0, 0, 0);
    random_phase(1'b0, 1'b0);

    // Narrowest range, all-ones limit and baselines: nothing is tilted.
    send_idle_pct = 0;
    recv_stall_pct = 70;
    apply_settings(15'd3, 32767, 32767, 32767, 32767);
    random_phase(1'b0, 1'b0);

    // Limit at pi: only a full half-turn from a baseline trips it.
    send_idle_pct = 29;
    recv_stall_pct = 29;
    apply_settings(15'd2, 31416, 31416, 0, 15708);
    random_phase(1'b0, 1'b0);

    // Random settings, one per idle mode.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_settings(15'($urandom_range(3)), $urandom_range(8000), $urandom_range(31416),
                   $urandom_range(31416), $urandom_range(31416));
    random_phase(1'b1, 1'b0);

    send_idle_pct = 70;
    apply_settings(15'($urandom_range(3)), $urandom_range(8000), $urandom_range(31416),
                   $urandom_range(31416), $urandom_range(31416));
    random_phase(1'b0, 1'b0);

    send_idle_pct = 0;
    recv_stall_pct = 70;
    apply_settings(15'($urandom_range(3)), $urandom_range(8000), $urandom_range(31416),
                   $urandom_range(31416), $urandom_range(31416));
    random_phase(1'b0, 1'b1);

    send_idle_pct = 29;
    recv_stall_pct = 29;
    apply_settings(15'($urandom_range(3)), $urandom_range(8000), $urandom_range(31416),
                   $urandom_range(31416), $urandom_range(31416));
    random_phase(1'b0, 1'b0);

    // Drain, then keep the clock running so that any stray result would show.
    wait_for_results();
    repeat (4) @(negedge clk);
    if (sb.pending_alarms.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never transferred", sb.pending_alarms.size()));
    end
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
